// ===== rtl/fdsc_pkg.sv =====
// fdsc_pkg: types, constants and fuzzy tables for the fuzzy differential speed controller.
// Used by every module in rtl/.
`timescale 1ns / 1ps
package fdsc_pkg;
	localparam int RuleLevels = 5;
	localparam int FracBits   = 8;
	localparam int ErrW       = 17 + FracBits;

	typedef struct packed {
		logic signed [15:0] steer_error;
		logic signed [15:0] speed_left;
		logic signed [15:0] speed_right;
	} in_item_t;

	typedef struct packed {
		logic signed [15:0] pwm_left;
		logic signed [15:0] pwm_right;
		logic signed [15:0] target_left;
		logic signed [15:0] target_right;
	} out_item_t;

	typedef enum logic [1:0] {
		REG_SPEED_GAIN = 2'd0,
		REG_ERROR_GAIN = 2'd1,
		REG_INT_GAIN   = 2'd2,
		REG_DER_GAIN   = 2'd3
	} reg_idx_t;

	// Floor of m / 5 by reciprocal multiply; exact for every 11-bit m.
	function automatic logic [8:0] div5(input logic [10:0] m);
		return 9'((25'(m) * 25'd13108) >> 16);
	endfunction

	// Steering fuzzifier: returns segment mu0 and level r for a non-negative Q8.8 value.
	function automatic logic [8:0] steer_mu(input logic [16:0] x, output logic [2:0] r);
		logic [8:0]  mu;
		logic [16:0] n;
		mu = 9'd256;
		r  = 3'd4;
		n  = '0;
		if (x < 17'd10240) begin
			r  = 3'd0;
			n  = 17'd10240 - x;
			mu = div5(n[13:3]);
		end else if (x < 17'd12800) begin
			r  = 3'd1;
			n  = 17'd12800 - x;
			mu = div5(n[11:1]);
		end else if (x < 17'd15360) begin
			r  = 3'd2;
			n  = 17'd15360 - x;
			mu = div5(n[11:1]);
		end else if (x < 17'd17920) begin
			r  = 3'd3;
			n  = 17'd17920 - x;
			mu = div5(n[11:1]);
		end
		return mu;
	endfunction

	function automatic logic signed [7:0] base_rule(input logic [2:0] i);
		case (i)
			3'd0: return 8'sd47;
			3'd1: return 8'sd46;
			3'd2: return 8'sd45;
			3'd3: return 8'sd44;
			default: return 8'sd43;
		endcase
	endfunction

	function automatic logic signed [7:0] diff_rule(input logic [2:0] i);
		case (i)
			3'd0: return 8'sd28;
			3'd1: return 8'sd20;
			3'd2: return 8'sd10;
			3'd3: return 8'sd3;
			default: return 8'sd0;
		endcase
	endfunction

	function automatic logic signed [7:0] kp_rule(input logic [2:0] i);
		case (i)
			3'd0: return -8'sd5;
			3'd1: return -8'sd2;
			3'd2: return 8'sd0;
			3'd3: return 8'sd2;
			default: return 8'sd5;
		endcase
	endfunction

	function automatic logic signed [15:0] sat16(input logic signed [47:0] v);
		if (v > 48'sd32767) return 16'sh7fff;
		if (v < -48'sd32768) return 16'sh8000;
		return v[15:0];
	endfunction
endpackage

// ===== rtl/fdsc_lane.sv =====
// fdsc_lane: one wheel's fuzzy gain and incremental PI update, pipelined in registers.
// Depends on fdsc_pkg.
`timescale 1ns / 1ps
module fdsc_lane import fdsc_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  logic signed [15:0]       speed,
	input  logic signed [15:0]       target,
	input  logic [15:0]              integral_gain,
	input  logic signed [15:0]       derivative_gain,
	output logic signed [15:0]       drive
);
	logic signed [ErrW-1:0] err_s1, prev_q;
	logic signed [15:0]     drive_q;
	logic [8:0]             mu_s1;
	logic [2:0]             r_s1;
	logic signed [12:0]     kp2_s2;
	logic signed [ErrW:0]   sum_s2, dif_s2;
	logic signed [ErrW-1:0] err_s2;
	logic signed [55:0]     pa_s3, pb_s3, pc_s3;
	logic [3:0]             vld_q;
	logic signed [ErrW-1:0] e_c;
	logic signed [ErrW-1:0] num_w;
	logic [8:0]             mu_c;
	logic [2:0]             r_c;
	logic signed [12:0]     kp_c;
	logic signed [55:0]     num_c;
	logic signed [47:0]     dl_c;

	assign e_c = (ErrW'(speed) <<< FracBits) - ErrW'(target);

	// Wheel breakpoints -8,-6,0,6,8 in Q8.8; divide by 6 as halve then reciprocal of 3.
	always_comb begin
		num_w = '0;
		mu_c  = 9'd256;
		r_c   = 3'd4;
		if (err_s1 < -ErrW'(2048)) begin
			r_c = 3'd0;
		end else if (err_s1 < -ErrW'(1536)) begin
			r_c = 3'd0;
			num_w = -ErrW'(1536) - err_s1;
			mu_c = 9'(num_w >>> 1);
		end else if (err_s1 < ErrW'(0)) begin
			r_c = 3'd1;
			num_w = -err_s1;
			mu_c = 9'((25'(num_w[10:1]) * 25'd21846) >> 16);
		end else if (err_s1 < ErrW'(1536)) begin
			r_c = 3'd2;
			num_w = ErrW'(1536) - err_s1;
			mu_c = 9'((25'(num_w[10:1]) * 25'd21846) >> 16);
		end else if (err_s1 < ErrW'(2048)) begin
			r_c = 3'd3;
			num_w = ErrW'(2048) - err_s1;
			mu_c = 9'(num_w >>> 1);
		end
	end

	always_comb begin
		kp_c = 13'(signed'({4'd0, mu_s1}) * kp_rule(3'd4 - r_s1));
		if (r_s1 != 3'd4)
			kp_c = kp_c + 13'(signed'({4'd0, 9'd256 - mu_s1}) * kp_rule(3'd3 - r_s1));
		if (kp_c > 0) kp_c = -kp_c;
	end

	// Num in units of 2^-(8+16); kp2 term * 2^7, Kd term * 2^8.
	assign num_c = pa_s3 + pb_s3 + pc_s3;
	assign dl_c  = (num_c < 0) ? 48'(-((-num_c) >>> 24)) : 48'(num_c >>> 24);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q   <= '0;
			prev_q  <= '0;
			drive_q <= '0;
		end else begin
			vld_q <= {vld_q[2:0], start};
			if (start) prev_q <= e_c;
			if (vld_q[3]) drive_q <= sat16(48'(drive_q) + dl_c);
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			err_s1 <= e_c;
			sum_s2 <= (ErrW+1)'(e_c) + (ErrW+1)'(prev_q);
			dif_s2 <= (ErrW+1)'(e_c) - (ErrW+1)'(prev_q);
		end
		if (vld_q[0]) begin
			mu_s1  <= mu_c;
			r_s1   <= r_c;
			err_s2 <= err_s1;
		end
		if (vld_q[1]) begin
			kp2_s2 <= kp_c;
		end
		if (vld_q[2]) begin
			pa_s3 <= (56'(kp2_s2) * 56'(err_s2)) <<< 7;
			pb_s3 <= 56'(signed'({1'b0, integral_gain})) * 56'(sum_s2);
			pc_s3 <= (56'(derivative_gain) * 56'(dif_s2)) <<< 8;
		end
	end

	assign drive = drive_q;
endmodule

// ===== rtl/fuzzy_differential_speed_control_core.sv =====
// Top level of the fuzzy differential speed controller.
// Depends on fdsc_pkg and fdsc_lane.
`timescale 1ns / 1ps
// Usage:
//   in_valid/in_ready carry one item per control tick: steer_error and both
//   wheel speeds. out_valid/out_ready return one item: new pwm for each wheel
//   and the two target speeds.
//   cfg_we/cfg_idx/cfg_data write gains; write only while idle.
// Pipeline:
//   One item is in flight at a time. Steering fuzzification and target
//   scaling are registered in bsum_s1/dsum_s1 and tl_q/tr_q, then both wheel
//   lanes run side by side (error, membership, fuzzy gain, three products,
//   sum and saturate), and the merge register presents the item with
//   out_valid. in_ready returns the cycle after the result is taken, so a
//   new item is accepted only once the previous one has been taken.
// Reset:
//   Gains return to their defaults, kept drives and previous errors clear.
// Stall:
//   A result waits in the output register until taken; a new item is accepted
//   only after that.
module fuzzy_differential_speed_control_core import fdsc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  in_item_t    in_data,
	output logic        out_valid,
	input  logic        out_ready,
	output out_item_t   out_data,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_idx,
	input  logic [15:0] cfg_data
);
	logic [15:0]        speed_gain_q, int_gain_q;
	logic [7:0]         err_gain_q;
	logic signed [15:0] der_gain_q;
	logic               busy_q, out_valid_q;
	logic [2:0]         cnt_q;
	in_item_t           item_q;
	logic [16:0]        mag_c;
	logic [8:0]         mu_c;
	logic [2:0]         r_c;
	logic [16:0]        bsum_c;
	logic [15:0]        dsum_c;
	logic [16:0]        bsum_s1;
	logic [15:0]        dsum_s1;
	logic signed [15:0] tl_q, tr_q, tl_c, tr_c;
	logic signed [47:0] base_c, diff_c;
	logic               lane_go;
	logic signed [15:0] drv_l, drv_r;
	out_item_t          out_q;

	function automatic logic [16:0] in_data_mag(input logic signed [15:0] v);
		return v[15] ? 17'(-17'(v)) : 17'(v);
	endfunction

	assign in_ready = !busy_q && !out_valid_q;
	assign mag_c = in_data_mag(item_q.steer_error);

	always_comb begin
		mu_c = steer_mu(mag_c, r_c);
		bsum_c = 17'(mu_c * 17'(base_rule(3'd4 - r_c)));
		dsum_c = 16'(mu_c * 16'(diff_rule(3'd4 - r_c)));
		if (r_c != 3'd4) begin
			bsum_c = bsum_c + 17'((9'd256 - mu_c) * 17'(base_rule(3'd3 - r_c)));
			dsum_c = dsum_c + 16'((9'd256 - mu_c) * 16'(diff_rule(3'd3 - r_c)));
		end
		base_c = 48'((33'(bsum_s1) * 33'(speed_gain_q)) >> 8);
		diff_c = 48'(dsum_s1) * 48'(err_gain_q);
		if (item_q.steer_error[15]) begin
			tr_c = sat16(base_c - diff_c);
			tl_c = sat16(base_c + (diff_c >>> 1));
		end else begin
			tl_c = sat16(base_c - diff_c);
			tr_c = sat16(base_c + (diff_c >>> 1));
		end
	end

	assign lane_go = busy_q && cnt_q == 3'd2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			speed_gain_q <= 16'd256;
			err_gain_q   <= 8'd1;
			int_gain_q   <= 16'd22938;
			der_gain_q   <= '0;
			busy_q       <= 1'b0;
			out_valid_q  <= 1'b0;
			cnt_q        <= '0;
		end else begin
			if (cfg_we) begin
				case (reg_idx_t'(cfg_idx))
					REG_SPEED_GAIN: speed_gain_q <= cfg_data;
					REG_ERROR_GAIN: err_gain_q   <= cfg_data[7:0];
					REG_INT_GAIN:   int_gain_q   <= cfg_data;
					REG_DER_GAIN:   der_gain_q   <= cfg_data;
					default: ;
				endcase
			end
			if (in_valid && in_ready) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 3'd1;
				if (cnt_q == 3'd7) begin
					busy_q      <= 1'b0;
					out_valid_q <= 1'b1;
				end
			end
			if (out_valid_q && out_ready) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) item_q <= in_data;
		if (busy_q && cnt_q == 3'd0) begin
			bsum_s1 <= bsum_c;
			dsum_s1 <= dsum_c;
		end
		if (busy_q && cnt_q == 3'd1) begin
			tl_q <= tl_c;
			tr_q <= tr_c;
		end
		if (busy_q && cnt_q == 3'd7) begin
			out_q.pwm_left     <= drv_l;
			out_q.pwm_right    <= drv_r;
			out_q.target_left  <= tl_q;
			out_q.target_right <= tr_q;
		end
	end

	fdsc_lane u_left (
		.clk(clk), .arst_n(arst_n), .start(lane_go), .speed(item_q.speed_left),
		.target(tl_q), .integral_gain(int_gain_q), .derivative_gain(der_gain_q),
		.drive(drv_l)
	);
	fdsc_lane u_right (
		.clk(clk), .arst_n(arst_n), .start(lane_go), .speed(item_q.speed_right),
		.target(tr_q), .integral_gain(int_gain_q), .derivative_gain(der_gain_q),
		.drive(drv_r)
	);

	assign out_valid = out_valid_q;
	assign out_data  = out_q;
endmodule
